// ===== rtl/fcsr_pkg.sv =====
// Shared types and constants for the flux conserving spectrum rebinner.
// Used by every module in rtl/; depends on nothing.
package fcsr_pkg;

  localparam int MAX_BINS  = 1024;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int CNT_W     = $clog2(MAX_BINS + 1);
  localparam int EDGE_W    = 40;
  localparam int SUM_W     = 48;
  localparam int SAMPLE_W  = 32;
  localparam int FRAC_BITS = 30;
  localparam int FRAC_W    = FRAC_BITS + 1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_BINS = 1'b0;
  localparam logic CFG_MASK = 1'b1;

  // variance of -1.0 in 16.16 marks a masked pixel
  localparam logic signed [SAMPLE_W-1:0] VAR_MASKED = 32'shFFFF_0000;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [CNT_W-1:0]           edge_index;
    logic [EDGE_W-1:0]          edge_value;
    logic [EDGE_W-1:0]          pixel_low;
    logic [EDGE_W-1:0]          pixel_high;
    logic signed [SAMPLE_W-1:0] pixel_flux;
    logic signed [SAMPLE_W-1:0] pixel_variance;
    logic                       pixel_skip;
    logic [BIN_W-1:0]           bin_index;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]        out_bin;
    logic signed [SUM_W-1:0] bin_flux;
    logic [SUM_W-1:0]        bin_variance;
    logic                    bin_masked;
  } out_item_t;

  typedef struct packed {
    logic                    mask;
    logic [SUM_W-1:0]        var_sum;
    logic signed [SUM_W-1:0] flux_sum;
  } acc_entry_t;

  typedef struct packed {
    logic              start;
    logic [EDGE_W-1:0] num;
    logic [EDGE_W-1:0] den;
  } div_req_t;

endpackage

// ===== rtl/fcsr_edge_ram.sv =====
// Bin edge memory: one write port, one registered read port.
// Depends on fcsr_pkg.
module fcsr_edge_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [fcsr_pkg::CNT_W-1:0] waddr,
  input  logic [fcsr_pkg::EDGE_W-1:0] wdata,
  input  logic [fcsr_pkg::CNT_W-1:0] raddr,
  output logic [fcsr_pkg::EDGE_W-1:0] rdata
);
  import fcsr_pkg::*;

  logic [EDGE_W-1:0] mem [MAX_BINS+1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcsr_acc_ram.sv =====
// Per-bin accumulator memory (flux sum, variance sum, mask bit).
// One write port, one registered read port. Depends on fcsr_pkg.
module fcsr_acc_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [fcsr_pkg::BIN_W-1:0] waddr,
  input  fcsr_pkg::acc_entry_t       wdata,
  input  logic [fcsr_pkg::BIN_W-1:0] raddr,
  output fcsr_pkg::acc_entry_t       rdata
);
  import fcsr_pkg::*;

  acc_entry_t mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcsr_frac_div.sv =====
// Restoring divider for the overlap fraction floor(num * 2^30 / den), num <= den.
// One quotient bit per cycle. Depends on fcsr_pkg.
module fcsr_frac_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fcsr_pkg::div_req_t          req,
  output logic                        done,
  output logic [fcsr_pkg::FRAC_W-1:0] quot
);
  import fcsr_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W + 1);

  logic [EDGE_W:0]     rem_r, rem_nxt;
  logic [EDGE_W-1:0]   den_r, den_nxt;
  logic [FRAC_W-1:0]   q_r, q_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic                bit_ge;
  logic [EDGE_W:0]     diff;

  always_comb begin
    bit_ge   = rem_r >= {1'b0, den_r};
    diff     = bit_ge ? rem_r - {1'b0, den_r} : rem_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = {1'b0, req.num};
      den_nxt  = req.den;
      q_nxt    = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      // shift in one quotient bit, drop the top remainder bit (always zero)
      q_nxt    = {q_r[FRAC_W-2:0], bit_ge};
      rem_nxt  = {diff[EDGE_W-1:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(FRAC_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/flux_conserving_spectrum_rebin.sv =====
// Top level of the flux conserving spectrum rebinner: command sequencer,
// edge and accumulator memories, fraction divider. Depends on fcsr_pkg.
//
// Usage. After reset the block runs a clearing pass over all 1024 bins
// of the accumulator memory with busy high; start is ignored then. An item
// is taken when start is high and busy is low. A load item writes one bin
// edge and leaves busy low. A read item moves the sequencer to S_RD, which
// loads the registered accumulator read of its bin into the output register;
// out_item then carries it with out_valid high for exactly one cycle, and
// the bin is cleared; the receiver cannot hold the result, so capture it.
// A pixel item fetches the outer edges (S_E0, S_EN), then scans edge by
// edge to find the first and the last overlapped bin (a linear walk through
// the edge memory, which has one read port), then per overlapped bin fetches
// its edges (S_BLO, S_BHI) and, with positive variance, runs S_OV, S_DIV
// (fraction divider), S_MULF, S_MULV and S_ACC, else may set the mask
// bit. The walk starts at the bottom edge; skipped pixels end in S_IDLE,
// out-of-grid ones in S_EN. Write configuration only while busy is low.
module flux_conserving_spectrum_rebin (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  fcsr_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output fcsr_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fcsr_pkg::CNT_W-1:0]  cfg_data
);
  import fcsr_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_E0, S_EN, S_I1, S_I2, S_BLO, S_BHI,
    S_OV, S_DIV, S_MULF, S_MULV, S_ACC, S_RD
  } state_t;

  localparam int PROD_W = SAMPLE_W + FRAC_W;

  state_t state_r, state_nxt;

  // configuration
  logic [CNT_W-1:0] n_r;
  logic             prop_r;

  // pixel context
  logic [EDGE_W-1:0]          lo_r, lo_nxt, hi_r, hi_nxt, w_r, w_nxt;
  logic [EDGE_W-1:0]          e0_r, e0_nxt, el_r, el_nxt;
  logic [EDGE_W-1:0]          top_r, top_nxt, bot_r, bot_nxt;
  logic signed [SAMPLE_W-1:0] flux_r, flux_nxt, var_r, var_nxt;
  logic                       hi_gt_en_r, hi_gt_en_nxt, hi_gt_en;
  logic                       neg_r, neg_nxt;
  logic [BIN_W-1:0]           j_r, j_nxt, i1_r, i1_nxt, i2_r, i2_nxt;
  logic [BIN_W-1:0]           k_r, k_nxt, bin_r, bin_nxt, clr_r, clr_nxt;
  logic [FRAC_W-1:0]          frac_r, frac_nxt;
  logic [SAMPLE_W-1:0]        pf_r, pf_nxt, pv_r, pv_nxt;
  acc_entry_t                 acc_r, acc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_item_r, out_item_nxt;

  // memory ports
  logic              edge_we;
  logic [CNT_W-1:0]  edge_raddr;
  logic [EDGE_W-1:0] edge_q;
  logic              acc_we;
  logic [BIN_W-1:0]  acc_waddr, acc_raddr;
  acc_entry_t        acc_wdata, acc_q;

  div_req_t          div_req;
  logic              div_done;
  logic [FRAC_W-1:0] div_q;

  // datapath temporaries
  logic [EDGE_W-1:0]   ov;
  logic                ov_neg;
  logic [SAMPLE_W-1:0] fmag, vmag;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W:0]   contrib_f, contrib_v;
  logic signed [SUM_W:0]   fsum;
  logic signed [SUM_W+1:0] vsum;
  logic                next_last;

  fcsr_edge_ram u_edge (
    .clk   (clk),
    .we    (edge_we),
    .waddr (in_item.edge_index),
    .wdata (in_item.edge_value),
    .raddr (edge_raddr),
    .rdata (edge_q)
  );

  fcsr_acc_ram u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_q)
  );

  fcsr_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  // a read item addresses its bin straight from the input; otherwise the
  // current bin of the pixel walk
  assign acc_raddr = (state_r == S_IDLE) ? in_item.bin_index : k_r;
  assign hi_gt_en  = (state_r == S_EN) ? (hi_r > edge_q) : hi_gt_en_r;
  assign next_last = ({1'b0, j_r} + 1'b1) == n_r;

  assign fmag = flux_r[SAMPLE_W-1] ? SAMPLE_W'(-flux_r) : SAMPLE_W'(flux_r);
  assign vmag = SAMPLE_W'(var_r);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    w_nxt         = w_r;
    e0_nxt        = e0_r;
    el_nxt        = el_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    flux_nxt      = flux_r;
    var_nxt       = var_r;
    hi_gt_en_nxt  = hi_gt_en_r;
    neg_nxt       = neg_r;
    j_nxt         = j_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    k_nxt         = k_r;
    bin_nxt       = bin_r;
    clr_nxt       = clr_r;
    frac_nxt      = frac_r;
    pf_nxt        = pf_r;
    pv_nxt        = pv_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    edge_we       = 1'b0;
    edge_raddr    = '0;
    acc_we        = 1'b0;
    acc_waddr     = k_r;
    acc_wdata     = acc_r;
    div_req       = '{start: 1'b0, num: '0, den: w_r};
    ov            = '0;
    ov_neg        = 1'b0;
    prod          = '0;
    contrib_f     = '0;
    contrib_v     = '0;
    fsum          = '0;
    vsum          = '0;

    case (state_r)
      S_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
        acc_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == BIN_W'(MAX_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          case (in_item.kind)
            KIND_LOAD: begin
              edge_we = in_item.edge_index <= CNT_W'(MAX_BINS);
            end
            KIND_PIXEL: begin
              if (!in_item.pixel_skip) begin
                lo_nxt    = in_item.pixel_low;
                hi_nxt    = in_item.pixel_high;
                flux_nxt  = in_item.pixel_flux;
                var_nxt   = in_item.pixel_variance;
                state_nxt = S_E0;
              end
            end
            KIND_READ: begin
              bin_nxt   = in_item.bin_index;
              state_nxt = S_RD;
            end
            default: begin
            end
          endcase
        end
      end

      S_E0: begin
        e0_nxt     = edge_q;
        edge_raddr = n_r;
        state_nxt  = S_EN;
      end

      S_EN: begin
        hi_gt_en_nxt = hi_gt_en;
        w_nxt        = hi_r - lo_r;
        if (hi_r <= e0_r || lo_r >= edge_q || lo_r == '0 || hi_r == '0 || hi_r <= lo_r)
        begin
          state_nxt = S_IDLE;
        end else if (lo_r > e0_r) begin
          j_nxt      = '0;
          edge_raddr = CNT_W'(1);
          state_nxt  = S_I1;
        end else begin
          // low edge at or below the first edge: first bin is bin 0
          i1_nxt = '0;
          if (hi_gt_en) begin
            i2_nxt     = BIN_W'(n_r - 1'b1);
            k_nxt      = '0;
            edge_raddr = '0;
            state_nxt  = S_BLO;
          end else begin
            j_nxt      = '0;
            edge_raddr = CNT_W'(1);
            state_nxt  = S_I2;
          end
        end
      end

      S_I1: begin
        if (lo_r <= edge_q || next_last) begin
          // no match at all falls back to bin 0
          i1_nxt = (lo_r <= edge_q) ? j_r : '0;
          if (hi_gt_en) begin
            i2_nxt     = BIN_W'(n_r - 1'b1);
            k_nxt      = (lo_r <= edge_q) ? j_r : '0;
            edge_raddr = (lo_r <= edge_q) ? {1'b0, j_r} : '0;
            state_nxt  = S_BLO;
          end else begin
            j_nxt      = (lo_r <= edge_q) ? j_r : '0;
            edge_raddr = (lo_r <= edge_q) ? ({1'b0, j_r} + 1'b1) : CNT_W'(1);
            state_nxt  = S_I2;
          end
        end else begin
          j_nxt      = j_r + 1'b1;
          edge_raddr = {1'b0, j_r} + CNT_W'(2);
        end
      end

      S_I2: begin
        if (hi_r <= edge_q || next_last) begin
          i2_nxt     = (hi_r <= edge_q) ? j_r : BIN_W'(n_r - 1'b1);
          k_nxt      = i1_r;
          edge_raddr = {1'b0, i1_r};
          state_nxt  = S_BLO;
        end else begin
          j_nxt      = j_r + 1'b1;
          edge_raddr = {1'b0, j_r} + CNT_W'(2);
        end
      end

      S_BLO: begin
        el_nxt     = edge_q;
        edge_raddr = {1'b0, k_r} + 1'b1;
        state_nxt  = S_BHI;
      end

      S_BHI: begin
        top_nxt = (hi_r < edge_q) ? hi_r : edge_q;
        bot_nxt = (lo_r > el_r) ? lo_r : el_r;
        acc_nxt = acc_q;
        if (var_r > 0) begin
          state_nxt = S_OV;
        end else begin
          if (!acc_q.mask && prop_r && var_r == VAR_MASKED) begin
            acc_we         = 1'b1;
            acc_wdata      = acc_q;
            acc_wdata.mask = 1'b1;
          end
          // advance to the next overlapped bin
          if (k_r == i2_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt      = k_r + 1'b1;
            edge_raddr = {1'b0, k_r} + 1'b1;
            state_nxt  = S_BLO;
          end
        end
      end

      S_OV: begin
        ov_neg  = top_r < bot_r;
        ov      = ov_neg ? bot_r - top_r : top_r - bot_r;
        if (ov > w_r) begin
          ov = w_r;
        end
        neg_nxt       = ov_neg;
        div_req.start = 1'b1;
        div_req.num   = ov;
        div_req.den   = w_r;
        state_nxt     = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          frac_nxt  = div_q;
          state_nxt = S_MULF;
        end
      end

      S_MULF: begin
        prod      = PROD_W'(fmag) * PROD_W'(frac_r);
        pf_nxt    = prod[FRAC_BITS +: SAMPLE_W];
        state_nxt = S_MULV;
      end

      S_MULV: begin
        prod      = PROD_W'(vmag) * PROD_W'(frac_r);
        pv_nxt    = prod[FRAC_BITS +: SAMPLE_W];
        state_nxt = S_ACC;
      end

      S_ACC: begin
        contrib_f = (flux_r[SAMPLE_W-1] ^ neg_r) ? -{1'b0, pf_r} : {1'b0, pf_r};
        contrib_v = neg_r ? -{1'b0, pv_r} : {1'b0, pv_r};
        fsum = {acc_r.flux_sum[SUM_W-1], acc_r.flux_sum}
             + {{(SUM_W-SAMPLE_W){contrib_f[SAMPLE_W]}}, contrib_f};
        vsum = {2'b00, acc_r.var_sum}
             + {{(SUM_W+1-SAMPLE_W){contrib_v[SAMPLE_W]}}, contrib_v};
        acc_we    = 1'b1;
        acc_wdata = acc_r;
        // saturate flux to the signed 48-bit range
        if (fsum[SUM_W] != fsum[SUM_W-1]) begin
          acc_wdata.flux_sum = fsum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          acc_wdata.flux_sum = fsum[SUM_W-1:0];
        end
        // variance holds once the bin is masked
        if (!acc_r.mask) begin
          if (vsum[SUM_W+1]) begin
            acc_wdata.var_sum = '0;
          end else if (vsum[SUM_W]) begin
            acc_wdata.var_sum = '1;
          end else begin
            acc_wdata.var_sum = vsum[SUM_W-1:0];
          end
        end
        if (k_r == i2_r) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt      = k_r + 1'b1;
          edge_raddr = {1'b0, k_r} + 1'b1;
          state_nxt  = S_BLO;
        end
      end

      S_RD: begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.out_bin      = bin_r;
        out_item_nxt.bin_flux     = acc_q.flux_sum;
        out_item_nxt.bin_variance = acc_q.var_sum;
        out_item_nxt.bin_masked   = acc_q.mask;
        acc_we                    = 1'b1;
        acc_waddr                 = bin_r;
        acc_wdata                 = '0;
        state_nxt                 = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      n_r         <= CNT_W'(MAX_BINS);
      prop_r      <= 1'b0;
      hi_gt_en_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      hi_gt_en_r  <= hi_gt_en_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BINS: begin
            // a count of zero acts as one, above the memory size as the size
            if (cfg_data == '0) begin
              n_r <= CNT_W'(1);
            end else if (cfg_data > CNT_W'(MAX_BINS)) begin
              n_r <= CNT_W'(MAX_BINS);
            end else begin
              n_r <= cfg_data;
            end
          end
          CFG_MASK: prop_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    w_r        <= w_nxt;
    e0_r       <= e0_nxt;
    el_r       <= el_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    flux_r     <= flux_nxt;
    var_r      <= var_nxt;
    neg_r      <= neg_nxt;
    j_r        <= j_nxt;
    i1_r       <= i1_nxt;
    i2_r       <= i2_nxt;
    k_r        <= k_nxt;
    bin_r      <= bin_nxt;
    frac_r     <= frac_nxt;
    pf_r       <= pf_nxt;
    pv_r       <= pv_nxt;
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_READ) |-> ##2 out_valid)
    else $error("read item did not report two cycles after acceptance");

  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_LOAD) |=> !busy)
    else $error("load item held the sequencer");

  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLO) |-> ({1'b0, k_r} < n_r && k_r <= i2_r))
    else $error("bin walk left the overlapped range");
`endif

endmodule

// ===== tb/flux_conserving_spectrum_rebin_tb.sv =====
// Self-checking testbench for flux_conserving_spectrum_rebin: drives edge loads,
// pixels and bin reads, predicts every bin report and compares it field by field.
// Depends on rtl/fcsr_pkg.sv and rtl/flux_conserving_spectrum_rebin.sv.
`timescale 1ns / 100ps

module flux_conserving_spectrum_rebin_tb;
  import fcsr_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;     // unused code, must do nothing
  localparam int         IDLE_LIMIT = 200000;  // cycles with no traffic at all
  localparam longint     FLUX_TOP = 64'sd140737488355327;
  localparam longint     FLUX_BOT = -64'sd140737488355328;
  localparam longint     VAR_TOP  = 64'sd281474976710655;
  localparam longint     EDGE_SPAN = 64'sd1099511627776;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [CNT_W-1:0] cfg_data;

  flux_conserving_spectrum_rebin dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: edge table, per-bin sums, mask bits, registers.
  // ---------------------------------------------------------------------
  logic [EDGE_W-1:0] edge_shadow [0:MAX_BINS];
  longint            flux_shadow [0:MAX_BINS-1];
  longint            var_shadow  [0:MAX_BINS-1];
  bit                mask_shadow [0:MAX_BINS-1];
  int unsigned       bins_reg;
  bit                mask_reg;

  out_item_t         pending_reports[$];
  int                mismatches;
  int                stray_reports;
  int                idle_cycles;
  int                burst_left;

  function automatic int unsigned live_bins();
    if (bins_reg < 1) return 1;
    if (bins_reg > MAX_BINS) return MAX_BINS;
    return bins_reg;
  endfunction

  function automatic longint unsigned fraction_of(longint unsigned ov, longint unsigned w);
    logic [71:0] num;
    num = {32'd0, ov[39:0]} << FRAC_BITS;
    return longint'(num / {32'd0, w[39:0]});
  endfunction

  // truncate toward zero, sign from sample times sign of overlap
  function automatic longint weighted(longint v, longint unsigned fr, bit neg);
    longint unsigned mag;
    longint p;
    mag = (v < 0) ? -v : v;
    p = longint'((mag * fr) >> FRAC_BITS);
    return ((v < 0) != neg) ? -p : p;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void spread_pixel(in_item_t x);
    int unsigned n, first, last;
    longint unsigned lo, hi, w, top, bot, ov, fr;
    longint fx, vr;
    bit neg;
    n = live_bins();
    lo = x.pixel_low;
    hi = x.pixel_high;
    fx = $signed(x.pixel_flux);
    vr = $signed(x.pixel_variance);
    first = 0;
    last = n - 1;
    if (hi <= edge_shadow[0] || lo >= edge_shadow[n]) return;
    if (lo == 0 || hi == 0 || hi <= lo) return;
    w = hi - lo;
    if (lo > edge_shadow[0])
      for (int j = 0; j < n; j++)
        if (lo <= edge_shadow[j+1]) begin
          first = j;
          break;
        end
    if (hi <= edge_shadow[n])
      for (int j = first; j < n; j++)
        if (hi <= edge_shadow[j+1]) begin
          last = j;
          break;
        end
    for (int k = first; k <= last && k < n; k++) begin
      if (vr > 0) begin
        top = (hi < edge_shadow[k+1]) ? hi : edge_shadow[k+1];
        bot = (lo > edge_shadow[k]) ? lo : edge_shadow[k];
        neg = top < bot;
        ov = neg ? bot - top : top - bot;
        if (ov > w) ov = w;
        fr = fraction_of(ov, w);
        flux_shadow[k] = clip(flux_shadow[k] + weighted(fx, fr, neg), FLUX_BOT, FLUX_TOP);
        if (!mask_shadow[k])
          var_shadow[k] = clip(var_shadow[k] + weighted(vr, fr, neg), 0, VAR_TOP);
      end else if (!mask_shadow[k] && mask_reg && x.pixel_variance == VAR_MASKED) begin
        mask_shadow[k] = 1'b1;
      end
    end
  endfunction

  // advance the shadow by one accepted item, queue the report it causes
  function automatic void apply_item(in_item_t x);
    out_item_t r;
    case (x.kind)
      KIND_LOAD: begin
        if (x.edge_index <= MAX_BINS) begin
          edge_shadow[x.edge_index] = x.edge_value;
        end
      end
      KIND_PIXEL: if (!x.pixel_skip) spread_pixel(x);
      KIND_READ: begin
        r.out_bin = x.bin_index;
        r.bin_flux = flux_shadow[x.bin_index][SUM_W-1:0];
        r.bin_variance = var_shadow[x.bin_index][SUM_W-1:0];
        r.bin_masked = mask_shadow[x.bin_index];
        flux_shadow[x.bin_index] = 0;
        var_shadow[x.bin_index] = 0;
        mask_shadow[x.bin_index] = 1'b0;
        pending_reports.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Report checker and watchdog. Both sample pre-edge values.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        stray_reports++;
        $display("unexpected report for bin %0d", out_item.out_bin);
      end else begin
        want = pending_reports.pop_front();
        if (want !== out_item) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("bin report mismatch: exp bin %0d flux %0d var %0d mask %0b",
                     want.out_bin, want.bin_flux, want.bin_variance, want.bin_masked);
            $display("                     got bin %0d flux %0d var %0d mask %0b",
                     out_item.out_bin, out_item.bin_flux, out_item.bin_variance,
                     out_item.bin_masked);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------
  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  // random item of the given kind, every other field random
  function automatic in_item_t rand_item(logic [1:0] k);
    logic [223:0] raw;
    in_item_t x;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    x = raw[$bits(in_item_t)-1:0];
    x.kind = k;
    return x;
  endfunction

  // Send one item; start stays high after acceptance so back-to-back items
  // follow without a gap. Bursts end in a random gap with start low.
  task automatic send_item(in_item_t x);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    in_item <= x;
    do @(posedge clk); while (busy);
    apply_item(x);
  endtask

  // Drop start, wait for every report and for busy to fall, then settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CNT_W-1:0];
    @(posedge clk);
    if (idx == CFG_BINS) bins_reg = val & 11'h7FF;
    else mask_reg = val[0];
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t blank_item(logic [1:0] k);
    in_item_t x;
    x = '0;
    x.kind = k;
    return x;
  endfunction

  task automatic load_edge(int idx, logic [EDGE_W-1:0] val);
    in_item_t x;
    x = blank_item(KIND_LOAD);
    x.edge_index = CNT_W'(idx);
    x.edge_value = val;
    send_item(x);
  endtask

  task automatic pixel(longint unsigned lo, longint unsigned hi, int fx, int vr, bit skip);
    in_item_t x;
    x = blank_item(KIND_PIXEL);
    x.pixel_low = EDGE_W'(lo);
    x.pixel_high = EDGE_W'(hi);
    x.pixel_flux = fx;
    x.pixel_variance = vr;
    x.pixel_skip = skip;
    send_item(x);
  endtask

  task automatic read_bin(int b);
    in_item_t x;
    x = blank_item(KIND_READ);
    x.bin_index = BIN_W'(b);
    send_item(x);
  endtask

  // Load an ascending grid over edges 0..n with random origin and pitch.
  task automatic load_grid(int n);
    longint unsigned pitch, origin, cap, step_cap;
    int sh;
    cap = (EDGE_SPAN - 1) / (n + 1);
    sh = $urandom_range(1, 34);
    step_cap = ((longint'(1) << sh) < cap) ? (longint'(1) << sh) : cap;
    pitch = 1 + rand64() % step_cap;
    origin = rand64() % (EDGE_SPAN - n * pitch);
    for (int i = 0; i <= n; i++) load_edge(i, EDGE_W'(origin + i * pitch));
  endtask

  function automatic longint unsigned point_in_bin(int b);
    longint unsigned d;
    d = (edge_shadow[b+1] > edge_shadow[b]) ? edge_shadow[b+1] - edge_shadow[b] : 0;
    if (d == 0 || $urandom_range(0, 4) == 0) return edge_shadow[b];
    return edge_shadow[b] + rand64() % d;
  endfunction

  function automatic int rand_variance();
    case ($urandom_range(0, 9))
      0: return VAR_MASKED;
      1: return -$urandom_range(0, 1000);
      2: return $urandom;
      default: return $urandom_range(1, 32'h7FFF_FFFF);
    endcase
  endfunction

  // Mostly well-formed pixels over the current grid, plus noise and reads.
  task automatic random_traffic(int count);
    int unsigned n, a, b, pick;
    longint unsigned lo, hi;
    n = live_bins();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        a = $urandom_range(0, n - 1);
        b = a + $urandom_range(0, 2);
        if (b > n - 1) b = n - 1;
        lo = point_in_bin(a);
        hi = ($urandom_range(0, 9) == 0) ? edge_shadow[n] + $urandom : point_in_bin(b) + 1;
        if (hi <= lo) hi = lo + $urandom_range(1, 65536);
        pixel(lo & 40'hFF_FFFF_FFFF, hi & 40'hFF_FFFF_FFFF, $urandom, rand_variance(),
              $urandom_range(0, 19) == 0);
      end else if (pick < 60) begin
        send_item(rand_item(KIND_PIXEL));
      end else if (pick < 88) begin
        read_bin(($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_BINS - 1)
                                             : $urandom_range(0, n - 1));
      end else if (pick < 94) begin
        send_item(rand_item(KIND_LOAD));
      end else begin
        send_item(rand_item(KIND_NONE));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_corner_pixels();
    longint unsigned u;
    in_item_t x;
    u = 64'd65536;
    write_reg(CFG_BINS, 4);
    write_reg(CFG_MASK, 1);
    for (int i = 0; i <= 4; i++) load_edge(i, EDGE_W'((i + 1) * 100 * u));
    load_edge(2047, 40'hFF_FFFF_FFFF);                   // out of range, ignored
    pixel(150 * u, 250 * u, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);  // flagged
    pixel(0, 250 * u, 1000, 1000, 1'b0);                 // zero low edge
    pixel(250 * u, 250 * u, 1000, 1000, 1'b0);           // empty
    pixel(300 * u, 200 * u, 1000, 1000, 1'b0);           // reversed
    pixel(10 * u, 90 * u, 1000, 1000, 1'b0);             // below the grid
    pixel(500 * u, 700 * u, 1000, 1000, 1'b0);           // above the grid
    pixel(100 * u, 180 * u, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0); // low on first edge
    pixel(50 * u, 460 * u, 32'h8000_0000, 32'h0000_0001, 1'b0);  // spans everything
    pixel(350 * u, 900 * u, -12345, 65536, 1'b0);        // past the last edge
    pixel(120 * u, 330 * u, 777, VAR_MASKED, 1'b0);      // masks bins 0..2
    pixel(130 * u, 140 * u, 4096, 65536, 1'b0);          // flux grows, variance held
    pixel(410 * u, 420 * u, 4096, 0, 1'b0);              // rejected variance
    pixel(410 * u, 420 * u, 4096, -65537, 1'b0);
    x = blank_item(KIND_NONE);
    x.bin_index = 1;
    send_item(x);
    for (int i = 0; i < 4; i++) read_bin(i);
    read_bin(MAX_BINS - 1);
    read_bin(0);                                          // cleared by first read
  endtask

  task automatic test_unordered_edges();
    longint unsigned u;
    u = 64'd65536;
    write_reg(CFG_BINS, 5);
    write_reg(CFG_MASK, 0);
    load_edge(0, EDGE_W'(100 * u));
    load_edge(1, EDGE_W'(300 * u));
    load_edge(2, EDGE_W'(200 * u));
    load_edge(3, EDGE_W'(400 * u));
    load_edge(4, EDGE_W'(350 * u));
    load_edge(5, EDGE_W'(600 * u));
    pixel(150 * u, 380 * u, 50000, 70000, 1'b0);
    pixel(250 * u, 550 * u, -50000, 70000, 1'b0);
    pixel(210 * u, 220 * u, 9999, VAR_MASKED, 1'b0);      // mask off: no effect
    for (int i = 0; i < 5; i++) read_bin(i);
  endtask

  task automatic test_bin_count(int unsigned count_reg, int grid, bit prop, int items);
    write_reg(CFG_BINS, count_reg);
    write_reg(CFG_MASK, prop);
    if (grid > 0) load_grid(grid);
    random_traffic(items);
  endtask

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_BINS;
    cfg_data <= '0;
    mismatches = 0;
    stray_reports = 0;
    idle_cycles = 0;
    burst_left = 0;
    bins_reg = MAX_BINS;
    mask_reg = 1'b0;
    for (int i = 0; i <= MAX_BINS; i++) begin
      edge_shadow[i] = '0;
    end
    for (int i = 0; i < MAX_BINS; i++) begin
      flux_shadow[i] = 0;
      var_shadow[i] = 0;
      mask_shadow[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_pixels();
    test_unordered_edges();
    test_bin_count(1, 1, 1'b1, 30);
    test_bin_count(0, 0, 1'b0, 20);           // zero count acts as one bin
    test_bin_count(3, 3, 1'b1, 40);
    test_bin_count(16, 16, 1'b0, 40);
    test_bin_count(64, 64, 1'b1, 40);
    test_bin_count(MAX_BINS, MAX_BINS, 1'b1, 20);
    test_bin_count(2047, 0, 1'b0, 20);        // clamps to the full grid

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && stray_reports == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fcsr_pkg.sv
rtl/fcsr_edge_ram.sv
rtl/fcsr_acc_ram.sv
rtl/fcsr_frac_div.sv
rtl/flux_conserving_spectrum_rebin.sv
tb/flux_conserving_spectrum_rebin_tb.sv
